FILE: src/baro_temp_compensation_macros.svh
// Assertion macros for the barometric compensation block.
`ifndef BARO_TEMP_COMPENSATION_MACROS_SVH
`define BARO_TEMP_COMPENSATION_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define BTC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never be seen on a clock edge.
`define BTC_NEVER(name, expr, msg) \
  `BTC_ASSERT(name, !(expr), msg)

`endif

FILE: src/btc_pkg.sv
// Shared types and constants for the barometric compensation block.
`default_nettype none

package btc_pkg;

  localparam int unsigned FineBias       = 128000;
  localparam int unsigned PressBase      = 1048576;
  localparam int unsigned NumScale       = 3125;
  localparam int unsigned CalOffsetShift = 47;
  localparam int unsigned P4Shift        = 35;
  localparam int unsigned DenShift       = 33;
  localparam int unsigned DenW           = 64 - DenShift;

  typedef enum logic [1:0] {
    CFG_TEMP       = 2'd0,
    CFG_PRESS_LOW  = 2'd1,
    CFG_PRESS_HIGH = 2'd2,
    CFG_PRESS_LAST = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } calib_t;

  // One classified reading pair, ready for the division.
  typedef struct packed {
    logic signed [63:0]     num;
    logic signed [DenW-1:0] den;
    logic                   err;
    logic signed [15:0]     tc;
    logic signed [31:0]     fine;
  } job_t;

endpackage

`default_nettype wire

FILE: src/btc_front.sv
// Front pipeline: temperature, divisor, numerator and divide-by-zero flag.
`default_nettype none

module btc_front import btc_pkg::*; (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  calib_t       calib_i,
  input  wire          in_valid_i,
  output logic         in_ready_o,
  input  wire   [19:0] temp_reading_i,
  input  wire   [19:0] press_reading_i,
  output logic         job_valid_o,
  input  wire          job_ready_i,
  output job_t         job_o
);

  localparam int unsigned Stages = 9;

  logic [Stages-1:0] v_q;
  logic              en;

  assign en          = !v_q[Stages-1] || job_ready_i;
  assign in_ready_o  = en;
  assign job_valid_o = v_q[Stages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[Stages-2:0], in_valid_i};
    end
  end

  // stage 0
  logic [19:0] traw_q, praw0_q;
  // stage 1
  logic signed [17:0] a_s;
  logic signed [16:0] b_s;
  logic signed [33:0] at2_d, bb_d;
  logic signed [33:0] at2_q;
  logic        [31:0] bb_q;
  logic        [19:0] praw1_q;
  // stage 2
  logic signed [36:0] tbp_d, tbp_q;
  logic signed [33:0] at2b_q;
  logic        [19:0] praw2_q;
  // stage 3
  logic        [23:0] fsum;
  logic signed [31:0] fine3_q;
  logic        [19:0] praw3_q;
  // stage 4
  logic signed [35:0] fx, t5;
  logic signed [27:0] t8;
  logic signed [15:0] tc_d;
  logic signed [25:0] v1;
  logic signed [51:0] vv_d, vv_q;
  logic signed [41:0] vp5_d, vp2_d, vp5_q, vp2_q;
  logic signed [15:0] tc4_q;
  logic signed [31:0] fine4_q;
  logic        [19:0] praw4_q;
  // stage 5
  logic signed [67:0] vvp6_full, vvp3_full;
  logic        [63:0] vvp6_q, vvp3_q, s_d, s_q;
  logic signed [41:0] vp2b_q;
  logic signed [15:0] tc5_q;
  logic signed [31:0] fine5_q;
  logic        [19:0] praw5_q;
  // stage 6
  logic        [20:0] pm;
  logic        [63:0] x_d, x_q, v2_q, pd_q;
  logic signed [15:0] tc6_q;
  logic signed [31:0] fine6_q;
  // stage 7
  logic signed [72:0] xp_full;
  logic        [63:0] xp_q, nd_q;
  logic signed [15:0] tc7_q;
  logic signed [31:0] fine7_q;
  // stage 8
  logic [63:0] num_d;
  job_t        job_q;

  assign a_s   = $signed({1'b0, traw_q[19:3]}) - $signed({1'b0, calib_i.t1, 1'b0});
  assign b_s   = $signed({1'b0, traw_q[19:4]}) - $signed({1'b0, calib_i.t1});
  assign at2_d = a_s * calib_i.t2;
  assign bb_d  = b_s * b_s;

  assign tbp_d = $signed({1'b0, bb_q[31:12]}) * calib_i.t3;

  assign fsum = {at2b_q[33], at2b_q[33:11]} + {tbp_q[36], tbp_q[36:14]};

  assign fx = {{4{fine3_q[31]}}, fine3_q};
  assign t5 = (fx <<< 2) + fx + 36'sd128;
  assign t8 = t5[35:8];
  always_comb begin
    if (t8 > 28'sd32767) begin
      tc_d = 16'sh7fff;
    end else if (t8 < -28'sd32768) begin
      tc_d = 16'sh8000;
    end else begin
      tc_d = t8[15:0];
    end
  end
  // fine stays within 24 bits, so the bias subtraction is exact in 26
  assign v1    = $signed(fine3_q[25:0]) - $signed(26'(FineBias));
  assign vv_d  = v1 * v1;
  assign vp5_d = v1 * calib_i.p5;
  assign vp2_d = v1 * calib_i.p2;

  assign vvp6_full = vv_q * calib_i.p6;
  assign vvp3_full = vv_q * calib_i.p3;
  assign s_d = (64'(vp5_q) << 17) + (64'(calib_i.p4) << P4Shift);

  assign pm  = 21'(PressBase) - {1'b0, praw5_q};
  assign x_d = 64'($signed(vvp3_q) >>> 8) + (64'(vp2b_q) << 12)
             + (64'd1 << CalOffsetShift);

  assign xp_full = $signed(x_q[55:0]) * $signed({1'b0, calib_i.p1});

  assign num_d = nd_q * 64'(NumScale);

  always_ff @(posedge clk_i) begin
    if (en) begin
      traw_q  <= temp_reading_i;
      praw0_q <= press_reading_i;

      at2_q   <= at2_d;
      bb_q    <= bb_d[31:0];
      praw1_q <= praw0_q;

      tbp_q   <= tbp_d;
      at2b_q  <= at2_q;
      praw2_q <= praw1_q;

      fine3_q <= {{8{fsum[23]}}, fsum};
      praw3_q <= praw2_q;

      vv_q    <= vv_d;
      vp5_q   <= vp5_d;
      vp2_q   <= vp2_d;
      tc4_q   <= tc_d;
      fine4_q <= fine3_q;
      praw4_q <= praw3_q;

      vvp6_q  <= vvp6_full[63:0];
      vvp3_q  <= vvp3_full[63:0];
      s_q     <= s_d;
      vp2b_q  <= vp2_q;
      tc5_q   <= tc4_q;
      fine5_q <= fine4_q;
      praw5_q <= praw4_q;

      v2_q    <= vvp6_q + s_q;
      x_q     <= x_d;
      pd_q    <= {12'b0, pm, 31'b0};
      tc6_q   <= tc5_q;
      fine6_q <= fine5_q;

      xp_q    <= xp_full[63:0];
      nd_q    <= pd_q - v2_q;
      tc7_q   <= tc6_q;
      fine7_q <= fine6_q;

      job_q.num  <= num_d;
      job_q.den  <= xp_q[63:DenShift];
      job_q.err  <= (xp_q[63:DenShift] == '0);
      job_q.tc   <= tc7_q;
      job_q.fine <= fine7_q;
    end
  end

  assign job_o = job_q;

endmodule

`default_nettype wire

FILE: src/btc_fifo.sv
// Short queue between the front and back pipelines.
`default_nettype none

module btc_fifo import btc_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   push_i,
  input  job_t  wdata_i,
  output logic  full_o,
  input  wire   pop_i,
  output logic  empty_o,
  output job_t  rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

FILE: src/btc_back.sv
// Back pipeline: 64-step restoring divider and final pressure correction.
`default_nettype none

module btc_back import btc_pkg::*; (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  calib_t             calib_i,
  input  wire                job_valid_i,
  output logic               job_ready_o,
  input  job_t               job_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic signed [15:0] temperature_centi_o,
  output logic signed [31:0] fine_temperature_o,
  output logic        [31:0] pressure_q24_8_o,
  output logic               divide_error_o
);

  localparam int unsigned DivSteps  = 64;
  localparam int unsigned LastStage = DivSteps + 7;

  typedef struct packed {
    logic               err;
    logic signed [15:0] tc;
    logic signed [31:0] fine;
    logic               neg;
  } side_t;

  logic [LastStage:0] vld_q;
  logic               en;
  side_t              side_q [LastStage+1];

  assign en          = !vld_q[LastStage] || out_ready_i;
  assign job_ready_o = en;
  assign out_valid_o = vld_q[LastStage];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LastStage-1:0], job_valid_i};
    end
  end

  // magnitudes enter the divider; sign is reapplied after it
  logic [63:0]     nmag;
  logic [DenW-1:0] dmag;
  assign nmag = job_i.num[63] ? 64'd0 - job_i.num : job_i.num;
  assign dmag = job_i.den[DenW-1] ? '0 - job_i.den : job_i.den;

  logic [63:0]     dq_q [DivSteps+1];
  logic [DenW-1:0] dr_q [DivSteps+1];
  logic [DenW-1:0] dd_q [DivSteps+1];
  logic [DenW:0]   rs_w [DivSteps];
  logic [DenW:0]   rn_w [DivSteps];
  logic            ge_w [DivSteps];

  always_comb begin
    for (int k = 0; k < DivSteps; k++) begin
      rs_w[k] = {dr_q[k], dq_q[k][63]};
      ge_w[k] = rs_w[k] >= {1'b0, dd_q[k]};
      rn_w[k] = ge_w[k] ? rs_w[k] - {1'b0, dd_q[k]} : rs_w[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dq_q[0]          <= nmag;
      dr_q[0]          <= '0;
      dd_q[0]          <= dmag;
      side_q[0].err    <= job_i.err;
      side_q[0].tc     <= job_i.tc;
      side_q[0].fine   <= job_i.fine;
      side_q[0].neg    <= job_i.num[63] ^ job_i.den[DenW-1];
      for (int k = 1; k <= DivSteps; k++) begin
        dq_q[k] <= {dq_q[k-1][62:0], ge_w[k-1]};
        dr_q[k] <= rn_w[k-1][DenW-1:0];
        dd_q[k] <= dd_q[k-1];
      end
      for (int k = 1; k <= LastStage; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // correction stages, 64-bit wrapping arithmetic built from narrow products
  logic        [63:0] p0_q, p1_q, p2_q, s1_q, s1b_q, s2_q, qq_q, w2f_q, w1f_q;
  logic        [51:0] ll_d, ll_q;
  logic signed [51:0] lh_d, lh_q;
  logic signed [49:0] hh_d, hh_q;
  logic signed [48:0] w2lo_d, w2lo_q, m9lo_d, m9lo_q;
  logic signed [47:0] w2hi_d, w2hi_q, m9hi_d, m9hi_q;
  logic        [25:0] ql;
  logic signed [24:0] qh;
  logic        [31:0] press_q, res;

  assign ql     = p0_q[38:13];
  assign qh     = p0_q[63:39];
  assign ll_d   = ql * ql;
  assign lh_d   = $signed({1'b0, ql}) * qh;
  assign hh_d   = qh * qh;
  assign w2lo_d = $signed({1'b0, p0_q[31:0]}) * calib_i.p8;
  assign w2hi_d = $signed(p0_q[63:32]) * calib_i.p8;

  assign m9lo_d = $signed({1'b0, qq_q[31:0]}) * calib_i.p9;
  assign m9hi_d = $signed(qq_q[63:32]) * calib_i.p9;

  assign res = s2_q[39:8] + {{12{calib_i.p7[15]}}, calib_i.p7, 4'b0};

  always_ff @(posedge clk_i) begin
    if (en) begin
      p0_q   <= side_q[DivSteps].neg ? 64'd0 - dq_q[DivSteps] : dq_q[DivSteps];

      ll_q   <= ll_d;
      lh_q   <= lh_d;
      hh_q   <= hh_d;
      w2lo_q <= w2lo_d;
      w2hi_q <= w2hi_d;
      p1_q   <= p0_q;

      qq_q   <= 64'(ll_q) + {lh_q[36:0], 27'b0} + {hh_q[11:0], 52'b0};
      w2f_q  <= 64'(w2lo_q) + {w2hi_q[31:0], 32'b0};
      p2_q   <= p1_q;

      m9lo_q <= m9lo_d;
      m9hi_q <= m9hi_d;
      s1_q   <= p2_q + 64'($signed(w2f_q) >>> 19);

      w1f_q  <= 64'(m9lo_q) + {m9hi_q[31:0], 32'b0};
      s1b_q  <= s1_q;

      s2_q   <= s1b_q + 64'($signed(w1f_q) >>> 25);

      press_q <= side_q[LastStage-1].err ? '0 : res;
    end
  end

  assign temperature_centi_o = side_q[LastStage].tc;
  assign fine_temperature_o  = side_q[LastStage].fine;
  assign divide_error_o      = side_q[LastStage].err;
  assign pressure_q24_8_o    = press_q;

endmodule

`default_nettype wire

FILE: src/baro_temp_compensation.sv
// Top level of the barometric temperature and pressure compensation block.
//
//  Channel   Handshake              Payload
//  -------   --------------------   --------------------------------------------
//  in        in_valid_i/in_ready_o  temp_reading_i, press_reading_i
//  out       out_valid_o/out_ready_i temperature_centi_o, fine_temperature_o,
//                                   pressure_q24_8_o, divide_error_o
//  cfg       cfg_we_i               cfg_idx_i, cfg_data_i
//
//  One reading pair per cycle while in_ready_o is high. A pair passes
//  through the front pipeline, the queue and the back, whose length is
//  set by the 64-stage divider. Reset clears calibration to zero and
//  empties all pipelines. An output stall freezes the back; the queue
//  lets the front keep taking transactions until it fills.
`default_nettype none
`include "baro_temp_compensation_macros.svh"

module baro_temp_compensation import btc_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire         [1:0]  cfg_idx_i,
  input  wire         [63:0] cfg_data_i,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  wire         [19:0] temp_reading_i,
  input  wire         [19:0] press_reading_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic signed [15:0] temperature_centi_o,
  output logic signed [31:0] fine_temperature_o,
  output logic        [31:0] pressure_q24_8_o,
  output logic               divide_error_o
);

  logic [47:0] temp_calib_q;
  logic [63:0] press_low_q, press_high_q;
  logic [15:0] press_last_q;
  calib_t      calib;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_calib_q <= '0;
      press_low_q  <= '0;
      press_high_q <= '0;
      press_last_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TEMP:       temp_calib_q <= cfg_data_i[47:0];
        CFG_PRESS_LOW:  press_low_q  <= cfg_data_i;
        CFG_PRESS_HIGH: press_high_q <= cfg_data_i;
        CFG_PRESS_LAST: press_last_q <= cfg_data_i[15:0];
      endcase
    end
  end

  assign calib.t1 = temp_calib_q[15:0];
  assign calib.t2 = temp_calib_q[31:16];
  assign calib.t3 = temp_calib_q[47:32];
  assign calib.p1 = press_low_q[15:0];
  assign calib.p2 = press_low_q[31:16];
  assign calib.p3 = press_low_q[47:32];
  assign calib.p4 = press_low_q[63:48];
  assign calib.p5 = press_high_q[15:0];
  assign calib.p6 = press_high_q[31:16];
  assign calib.p7 = press_high_q[47:32];
  assign calib.p8 = press_high_q[63:48];
  assign calib.p9 = press_last_q;

  job_t front_job, back_job;
  logic front_valid, q_full, q_empty, q_push, q_pop, back_ready;

  btc_front u_front (
    .clk_i,
    .rst_ni,
    .calib_i         (calib),
    .in_valid_i,
    .in_ready_o,
    .temp_reading_i,
    .press_reading_i,
    .job_valid_o     (front_valid),
    .job_ready_i     (!q_full),
    .job_o           (front_job)
  );

  assign q_push = front_valid && !q_full;
  assign q_pop  = back_ready && !q_empty;

  btc_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (q_push),
    .wdata_i (front_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .rdata_o (back_job)
  );

  btc_back u_back (
    .clk_i,
    .rst_ni,
    .calib_i             (calib),
    .job_valid_i         (!q_empty),
    .job_ready_o         (back_ready),
    .job_i               (back_job),
    .out_valid_o,
    .out_ready_i,
    .temperature_centi_o,
    .fine_temperature_o,
    .pressure_q24_8_o,
    .divide_error_o
  );

  `BTC_ASSERT(a_err_zero, out_valid_o && divide_error_o |-> pressure_q24_8_o == '0, "pressure not zero on divide error")
  `BTC_NEVER(a_push_full, front_valid && q_full && q_push, "queue written while full")
  `BTC_ASSERT(a_pop_stall, q_pop |=> !$past(q_empty), "queue read while empty")

endmodule

`default_nettype wire
